### rtl/fmpr_pkg.sv
// shared types and constants for the flow meter pulse front end
package fmpr_pkg;

	// divider geometry: widest dividend is count << 20, widest divisor is interval * ppl
	localparam int DVD_W = 52;
	localparam int DVS_W = 48;
	localparam int CNT_W = 6;
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

	// flow numerator: 60e6 us per minute in Q16.16
	localparam logic [DVD_W-1:0] FLOW_NUMER = 52'd3932160000000;
	localparam int VOL_FRAC = 20;
	localparam logic [9:0] VOL_SCALE = 10'd1000;

	// input actions
	localparam logic ACT_PULSE = 1'b0;
	localparam logic ACT_POLL  = 1'b1;

	// result kinds
	localparam logic KIND_FLOW = 1'b0;
	localparam logic KIND_VOL  = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_PPL      = 2'd1;
	localparam logic [1:0] REG_MAX_FLOW = 2'd2;
	localparam logic [1:0] REG_ZERO_MS  = 2'd3;

	// configuration reset values
	localparam logic [31:0] DEF_DEBOUNCE = 32'd1000;
	localparam logic [15:0] DEF_PPL      = 16'd450;
	localparam logic [31:0] DEF_MAX_FLOW = 32'hFFFF_FFFF;
	localparam logic [31:0] DEF_ZERO_MS  = 32'd1000;

	// controller to datapath commands
	typedef struct packed {
		logic take;
		logic pulse_upd;
		logic poll_upd;
		logic den_flow;
		logic div_start;
		logic div_vol;
		logic div_commit;
		logic out_flow;
		logic out_vol;
	} fmpr_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_poll;
		logic flow_go;
		logic count_chg;
		logic div_done;
		logic flow_emit;
		logic vol_emit;
		logic out_free;
	} fmpr_sts_t;

endpackage

### rtl/flow_meter_pulse_rate_volume_top.sv
// Flow meter pulse front end, top level. Each request is taken one at a time.
// A pulse request that leaves the flow alone returns to idle after decode. A
// pulse request that updates the flow and a poll after the pulse count has
// changed each run a division; a poll with a report to give also waits while
// the output register is still held. The divisions use a 52-step restoring
// divider, one quotient bit per cycle, shared by the flow rate and volume
// calculations. Results sit in an output register, so a new request is taken
// while the last result of a poll still waits. Configuration writes are
// always ready and must be issued only while the block is idle.
module flow_meter_pulse_rate_volume_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [31:0] time_us,
	input  logic [31:0] time_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [47:0] value,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import fmpr_pkg::*;

	fmpr_cmd_t cmd;
	fmpr_sts_t sts;

	// configuration writes never wait
	assign cfg_ready = 1'b1;

	fmpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	fmpr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.action    (action),
		.time_us   (time_us),
		.time_ms   (time_ms),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.value     (value),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

### rtl/fmpr_div.sv
// restoring divider, one quotient bit per cycle
module fmpr_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fmpr_pkg::DVD_W-1:0] dividend,
	input  logic [fmpr_pkg::DVS_W-1:0] divisor,
	output logic                       done,
	output logic [fmpr_pkg::DVD_W-1:0] quotient
);
	import fmpr_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] dq_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, dq_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			dq_q  <= {dq_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

### rtl/fmpr_dp.sv
// datapath: configuration, meter state, divider and output register
module fmpr_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fmpr_pkg::fmpr_cmd_t  cmd,
	output fmpr_pkg::fmpr_sts_t  sts,
	input  logic                 action,
	input  logic [31:0]          time_us,
	input  logic [31:0]          time_ms,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 kind,
	output logic [47:0]          value,
	output logic                 last,
	input  logic                 cfg_valid,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	import fmpr_pkg::*;

	// configuration
	logic [31:0] debounce_q;
	logic [15:0] ppl_q;
	logic [31:0] max_flow_q;
	logic [31:0] zero_ms_q;

	// latched request
	logic        action_q;
	logic [31:0] time_us_q;
	logic [31:0] time_ms_q;

	// meter state
	logic [31:0] prev_pulse_us_q;
	logic [31:0] last_real_ms_q;
	logic [31:0] pulse_total_q;
	logic [31:0] rep_total_q;
	logic [31:0] flow_rate_q;
	logic [31:0] rep_flow_q;
	logic [47:0] rep_vol_q;

	// poll bookkeeping
	logic        flow_emit_q;
	logic        vol_emit_q;
	logic [31:0] flow_val_q;

	// divide operands
	logic [31:0] interval_q;
	logic [47:0] den_q;

	// output register
	logic        out_valid_q;
	logic        kind_q;
	logic [47:0] value_q;
	logic        last_q;

	logic [31:0] interval;
	logic [31:0] quiet;
	logic [47:0] flow_den;
	logic [25:0] vol_den;
	logic [DVD_W-1:0] dividend;
	logic [DVD_W-1:0] quotient;
	logic        div_done;
	logic [31:0] flow_sat;
	logic [47:0] vol_new;
	logic        out_free;

	// interval arithmetic and divisor products
	always_comb begin
		interval = time_us_q - prev_pulse_us_q;
		quiet    = time_ms_q - last_real_ms_q;
		flow_den = interval_q * ppl_q;
		vol_den  = ppl_q * VOL_SCALE;
		dividend = cmd.div_vol ? {rep_total_q, {VOL_FRAC{1'b0}}} : FLOW_NUMER;
		flow_sat = (quotient[DVD_W-1:32] != '0) ? 32'hFFFF_FFFF : quotient[31:0];
		vol_new  = quotient[47:0];
		out_free = !out_valid_q || !out_stall;
	end

	fmpr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// status back to the controller
	always_comb begin
		sts.is_poll   = action_q == ACT_POLL;
		sts.flow_go   = (interval != '0) && (interval >= debounce_q);
		sts.count_chg = pulse_total_q != rep_total_q;
		sts.div_done  = div_done;
		sts.flow_emit = flow_emit_q;
		sts.vol_emit  = vol_emit_q;
		sts.out_free  = out_free;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEF_DEBOUNCE;
			ppl_q      <= DEF_PPL;
			max_flow_q <= DEF_MAX_FLOW;
			zero_ms_q  <= DEF_ZERO_MS;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data;
				REG_PPL:      ppl_q      <= cfg_data[15:0];
				REG_MAX_FLOW: max_flow_q <= cfg_data;
				REG_ZERO_MS:  zero_ms_q  <= cfg_data;
				default:      ;
			endcase
		end
	end

	// request capture and divisor operands
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			action_q  <= action;
			time_us_q <= time_us;
			time_ms_q <= time_ms;
		end
		if (cmd.pulse_upd) begin
			interval_q <= interval;
		end
		if (cmd.den_flow) begin
			den_q <= flow_den;
		end else if (cmd.poll_upd) begin
			den_q <= {22'b0, vol_den};
		end
		if (cmd.poll_upd) begin
			flow_val_q <= flow_rate_q;
		end
	end

	// meter state and poll bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pulse_us_q <= '0;
			last_real_ms_q  <= '0;
			pulse_total_q   <= '0;
			rep_total_q     <= '0;
			flow_rate_q     <= '0;
			rep_flow_q      <= '0;
			rep_vol_q       <= '0;
			flow_emit_q     <= 1'b0;
			vol_emit_q      <= 1'b0;
		end else begin
			if (cmd.pulse_upd) begin
				prev_pulse_us_q <= time_us_q;
				pulse_total_q   <= pulse_total_q + 1'b1;
				if (interval != '0) begin
					last_real_ms_q <= time_ms_q;
				end
			end
			if (cmd.poll_upd) begin
				flow_emit_q <= (flow_rate_q != rep_flow_q) && (flow_rate_q < max_flow_q);
				rep_flow_q  <= flow_rate_q;
				rep_total_q <= pulse_total_q;
				vol_emit_q  <= 1'b0;
				if (quiet > zero_ms_q) begin
					flow_rate_q <= '0;
				end
			end
			if (cmd.div_commit) begin
				if (!cmd.div_vol) begin
					flow_rate_q <= flow_sat;
				end else if (vol_new != rep_vol_q) begin
					rep_vol_q  <= vol_new;
					vol_emit_q <= 1'b1;
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_flow || cmd.out_vol) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.out_flow) begin
			kind_q  <= KIND_FLOW;
			value_q <= {16'b0, flow_val_q};
			last_q  <= !vol_emit_q;
		end else if (cmd.out_vol) begin
			kind_q  <= KIND_VOL;
			value_q <= rep_vol_q;
			last_q  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value     = value_q;
	assign last      = last_q;

endmodule

### rtl/fmpr_ctrl.sv
// controller: sequences pulse and poll requests over the datapath
module fmpr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  fmpr_pkg::fmpr_sts_t  sts,
	output fmpr_pkg::fmpr_cmd_t  cmd
);
	import fmpr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT_FLOW,
		ST_EMIT_VOL
	} state_t;

	state_t state_q;
	logic   div_vol_q;

	// state register and divide selection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_vol_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					if (sts.is_poll) begin
						div_vol_q <= 1'b1;
						state_q   <= sts.count_chg ? ST_DIV_GO : ST_EMIT_FLOW;
					end else begin
						div_vol_q <= 1'b0;
						state_q   <= sts.flow_go ? ST_MUL : ST_IDLE;
					end
				end
				ST_MUL: state_q <= ST_DIV_GO;
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (sts.div_done) state_q <= div_vol_q ? ST_EMIT_FLOW : ST_IDLE;
				end
				ST_EMIT_FLOW: begin
					if (!sts.flow_emit || sts.out_free) state_q <= ST_EMIT_VOL;
				end
				ST_EMIT_VOL: begin
					if (!sts.vol_emit || sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		in_stall       = state_q != ST_IDLE;
		cmd            = '0;
		cmd.div_vol    = div_vol_q;
		cmd.take       = (state_q == ST_IDLE) && in_valid;
		cmd.pulse_upd  = (state_q == ST_DECODE) && !sts.is_poll;
		cmd.poll_upd   = (state_q == ST_DECODE) && sts.is_poll;
		cmd.den_flow   = state_q == ST_MUL;
		cmd.div_start  = state_q == ST_DIV_GO;
		cmd.div_commit = (state_q == ST_DIV_WAIT) && sts.div_done;
		cmd.out_flow   = (state_q == ST_EMIT_FLOW) && sts.flow_emit && sts.out_free;
		cmd.out_vol    = (state_q == ST_EMIT_VOL) && sts.vol_emit && sts.out_free;
	end

endmodule

### rtl/fmpr_chk.sv
// port-level checks for the flow meter front end, bound to the top level
module fmpr_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        kind,
	input logic [47:0] value,
	input logic        last
);
	import fmpr_pkg::*;

	// a taken request always keeps the block busy for the following cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request taken without busy cycle");

	// only a flow report can be followed by another report of the same poll
	a_nonlast_is_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (kind == KIND_FLOW))
		else $error("volume report not marked last");

	// flow reports carry a 32-bit value
	a_flow_width: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_FLOW) |-> (value[47:32] == 16'h0))
		else $error("flow report with high bits set");

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(kind) && $stable(value) && $stable(last)))
		else $error("stalled result changed");

endmodule

bind flow_meter_pulse_rate_volume_top fmpr_chk u_chk (.*);

### test/fmpr_report_checker.sv
// report checker for the flow meter front end: predicts every report and compares
module fmpr_report_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        action,
	input  logic [31:0] time_us,
	input  logic [31:0] time_ms,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        kind,
	input  logic [47:0] value,
	input  logic        last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending
);
	import fmpr_pkg::*;

	typedef struct packed {
		logic        kind;
		logic [47:0] value;
		logic        last;
	} meter_report_t;

	// 60e6 us per minute, scaled to Q16.16
	localparam logic [63:0] MINUTE_Q16 = 64'd60000000 << 16;
	localparam logic [63:0] LITERS_PER_M3 = 64'd1000;

	// register copies
	logic [31:0] min_gap_us;
	logic [15:0] ppl_cfg;
	logic [31:0] flow_ceiling;
	logic [31:0] quiet_ms;

	// meter state copies
	logic [31:0] prev_us;
	logic [31:0] last_pulse_ms;
	logic [31:0] pulse_count;
	logic [31:0] shown_count;
	logic [31:0] flow_now;
	logic [31:0] shown_flow;
	logic [47:0] shown_volume;

	meter_report_t reports_due[$];

	// flow in Q16.16 l/min for one pulse interval, saturating
	function automatic logic [31:0] flow_for_interval(input logic [31:0] ivl);
		logic [63:0] den;
		logic [63:0] quo;
		den = 64'(ivl) * 64'(ppl_cfg);
		if (den == 64'd0)
			return 32'hFFFF_FFFF;
		quo = MINUTE_Q16 / den;
		return (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
	endfunction

	// volume in Q28.20 cubic meters for a pulse count
	function automatic logic [47:0] volume_for_count(input logic [31:0] cnt);
		logic [63:0] den;
		logic [63:0] quo;
		den = 64'(ppl_cfg) * LITERS_PER_M3;
		if (den == 64'd0)
			return 48'hFFFF_FFFF_FFFF;
		quo = (64'(cnt) << 20) / den;
		return quo[47:0];
	endfunction

	// advance the meter state for one request, queue the reports it causes
	function automatic void apply_request(input logic act, input logic [31:0] tus,
			input logic [31:0] tms);
		logic [31:0] ivl;
		logic [31:0] quiet_for;
		logic [47:0] vol;
		meter_report_t fresh[$];
		if (act == ACT_PULSE) begin
			ivl = tus - prev_us;
			prev_us = tus;
			pulse_count = pulse_count + 32'd1;
			if (ivl != 32'd0) begin
				last_pulse_ms = tms;
				if (ivl >= min_gap_us)
					flow_now = flow_for_interval(ivl);
			end
			return;
		end
		// flow report when changed and below the ceiling
		if (flow_now != shown_flow) begin
			shown_flow = flow_now;
			if (flow_now < flow_ceiling)
				fresh.push_back('{KIND_FLOW, 48'(flow_now), 1'b0});
		end
		// quiet meter forces flow to zero, reported on a later poll
		quiet_for = tms - last_pulse_ms;
		if (quiet_for > quiet_ms)
			flow_now = 32'd0;
		// volume report when the count moved and the volume changed
		if (pulse_count != shown_count) begin
			shown_count = pulse_count;
			vol = volume_for_count(pulse_count);
			if (vol != shown_volume) begin
				shown_volume = vol;
				fresh.push_back('{KIND_VOL, vol, 1'b0});
			end
		end
		if (fresh.size() > 0)
			fresh[fresh.size() - 1].last = 1'b1;
		foreach (fresh[i])
			reports_due.push_back(fresh[i]);
	endfunction

	// compare one accepted report with the oldest prediction
	function automatic void check_report();
		meter_report_t want;
		if (reports_due.size() == 0) begin
			errors++;
			$display("%0t: unexpected report, expected none, actual kind %0d value %0h last %0d",
				$time, kind, value, last);
			return;
		end
		want = reports_due.pop_front();
		if (kind !== want.kind) begin
			errors++;
			$display("%0t: kind mismatch, expected %0d actual %0d", $time, want.kind, kind);
		end
		if (value !== want.value) begin
			errors++;
			$display("%0t: value mismatch, expected %0h actual %0h", $time, want.value, value);
		end
		if (last !== want.last) begin
			errors++;
			$display("%0t: last mismatch, expected %0d actual %0d", $time, want.last, last);
		end
	endfunction

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_us = DEF_DEBOUNCE;
			ppl_cfg = DEF_PPL;
			flow_ceiling = DEF_MAX_FLOW;
			quiet_ms = DEF_ZERO_MS;
			prev_us = '0;
			last_pulse_ms = '0;
			pulse_count = '0;
			shown_count = '0;
			flow_now = '0;
			shown_flow = '0;
			shown_volume = '0;
			reports_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall)
				check_report();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEBOUNCE: min_gap_us = cfg_data;
					REG_PPL:      ppl_cfg = cfg_data[15:0];
					REG_MAX_FLOW: flow_ceiling = cfg_data;
					REG_ZERO_MS:  quiet_ms = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				apply_request(action, time_us, time_ms);
			pending = reports_due.size();
		end
	end

endmodule

### test/flow_meter_pulse_rate_volume_top_tb.sv
// testbench top for the flow meter front end: clock, reset, stimulus and verdict
module flow_meter_pulse_rate_volume_top_tb;
	import fmpr_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 120;
	localparam int PHASE_COUNT = 8;
	localparam int HOLD_PHASE = PHASE_COUNT - 1;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        action;
	logic [31:0] time_us;
	logic [31:0] time_ms;
	logic        out_valid;
	logic        out_stall;
	logic        kind;
	logic [47:0] value;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	// handshakes seen at the last rising edge
	logic in_taken = 1'b0;
	logic out_taken = 1'b0;
	logic cfg_taken = 1'b0;

	logic in_idle_on = 1'b1;
	logic out_idle_on = 1'b1;
	logic hold_req = 1'b0;

	// running meter clocks and pulse period for well-formed traffic
	logic [31:0] t_us;
	logic [31:0] t_ms;
	logic [31:0] period_us;

	int errors;
	int pending;
	int cycle_count = 0;

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	flow_meter_pulse_rate_volume_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.time_us   (time_us),
		.time_ms   (time_ms),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.value     (value),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fmpr_report_checker report_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.time_us   (time_us),
		.time_ms   (time_ms),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.value     (value),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	// record handshakes for the negedge drivers
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		out_taken <= out_valid && !out_stall;
		cfg_taken <= cfg_valid && cfg_ready;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// report receiver: random stall before each report, one long hold on demand
	initial begin : receiver
		int stall_cycles;
		logic hold_used;
		out_stall = 1'b0;
		hold_used = 1'b0;
		forever begin
			if (hold_req && !hold_used) begin
				hold_used = 1'b1;
				stall_cycles = HOLD_CYCLES;
			end else begin
				stall_cycles = out_idle_on ? $urandom_range(0, 9) : 0;
			end
			if (stall_cycles > 0) begin
				out_stall = 1'b1;
				repeat (stall_cycles) @(negedge clk);
				out_stall = 1'b0;
			end
			do @(negedge clk); while (!out_taken);
		end
	end

	// offer one request and wait until it is taken; valid stays high afterwards
	task automatic send_request(input logic act, input logic [31:0] tus,
			input logic [31:0] tms);
		int gap;
		gap = in_idle_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		time_us = tus;
		time_ms = tms;
		do @(negedge clk); while (!in_taken);
	endtask

	// stop offering, wait for every report, then let a pulse division finish
	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(negedge clk); while (!cfg_taken);
	endtask

	task automatic write_config(input logic [31:0] gap_us, input logic [31:0] ppl_word,
			input logic [31:0] ceiling, input logic [31:0] quiet);
		wait_idle();
		write_reg(REG_DEBOUNCE, gap_us);
		write_reg(REG_PPL, ppl_word);
		write_reg(REG_MAX_FLOW, ceiling);
		write_reg(REG_ZERO_MS, quiet);
		cfg_valid = 1'b0;
	endtask

	// one random request, mostly a plausible meter stream
	task automatic random_item();
		int pick;
		logic [31:0] step_us;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			period_us = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 5000);
		end
		if (pick < 48) begin
			// pulse at the running period with some jitter
			step_us = period_us + $urandom_range(0, period_us / 8);
			t_us = t_us + step_us;
			t_ms = t_ms + step_us / 1000 + $urandom_range(0, 1);
			send_request(ACT_PULSE, t_us, t_ms);
		end else if (pick < 55) begin
			// repeated stamp, counts only
			send_request(ACT_PULSE, t_us, t_ms + $urandom_range(0, 3));
		end else if (pick < 77) begin
			t_ms = t_ms + $urandom_range(0, 50);
			send_request(ACT_POLL, t_us, t_ms);
		end else if (pick < 87) begin
			// poll after a possibly quiet stretch
			t_ms = t_ms + $urandom_range(0, 3000);
			send_request(ACT_POLL, t_us, t_ms);
		end else begin
			send_request(1'($urandom_range(0, 1)), $urandom, $urandom);
		end
	endtask

	initial begin : stimulus
		in_valid = 1'b0;
		action = ACT_PULSE;
		time_us = '0;
		time_ms = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_DEBOUNCE;
		cfg_data = '0;
		t_us = '0;
		t_ms = '0;
		period_us = 32'd1000;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset settings
		send_request(ACT_POLL, 32'd0, 32'd0);
		send_request(ACT_PULSE, 32'd0, 32'd0);
		send_request(ACT_POLL, 32'd0, 32'd1);
		send_request(ACT_PULSE, 32'd2000, 32'd2);
		send_request(ACT_PULSE, 32'd2500, 32'd3);
		send_request(ACT_POLL, 32'd0, 32'd3);
		send_request(ACT_PULSE, 32'hFFFF_FFFF, 32'd10);
		send_request(ACT_PULSE, 32'd1499, 32'd11);
		send_request(ACT_PULSE, 32'd1499, 32'd12);
		send_request(ACT_POLL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(ACT_POLL, 32'd0, 32'hFFFF_FFFF);
		send_request(ACT_POLL, 32'd0, 32'd0);
		send_request(ACT_PULSE, 32'd2500, 32'd20);
		send_request(ACT_POLL, 32'd0, 32'd20);

		// directed: no debounce, one pulse per liter, saturating flow
		write_config(32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0);
		send_request(ACT_PULSE, 32'd2501, 32'd21);
		send_request(ACT_POLL, 32'd0, 32'd21);
		send_request(ACT_PULSE, 32'd2501, 32'd21);

		// directed: zero pulses per liter
		write_config(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
		send_request(ACT_PULSE, 32'd3000, 32'd22);
		send_request(ACT_POLL, 32'd0, 32'd22);
		send_request(ACT_POLL, 32'd0, 32'd25);
		send_request(ACT_POLL, 32'd0, 32'd25);
		t_us = 32'd3000;
		t_ms = 32'd30;

		// random phases over several register settings
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: write_config(DEF_DEBOUNCE, 32'(DEF_PPL), DEF_MAX_FLOW, DEF_ZERO_MS);
				1: write_config(32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0);
				2: write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
				3: write_config($urandom_range(0, 4000), $urandom_range(1, 2000),
					$urandom_range(0, 32'h0200_0000), $urandom_range(0, 3000));
				4: write_config(32'd500, 32'd0, 32'hFFFF_FFFF, 32'd1000);
				5: write_config(32'd500, 32'd450, 32'h0080_0000, 32'd200);
				6: write_config($urandom, $urandom, $urandom, $urandom);
				default: write_config(DEF_DEBOUNCE, 32'(DEF_PPL), DEF_MAX_FLOW, DEF_ZERO_MS);
			endcase
			period_us = $urandom_range(200, 3000);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0) begin
					in_idle_on = ($urandom_range(0, 3) != 0);
					out_idle_on = ($urandom_range(0, 3) != 0);
				end
				// long receiver hold while the sender keeps pushing
				if (ph == HOLD_PHASE && n == 40) begin
					hold_req = 1'b1;
					in_idle_on = 1'b0;
				end
				if (ph == HOLD_PHASE && n >= 40 && n < 80)
					in_idle_on = 1'b0;
				random_item();
			end
		end

		wait_idle();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### flow_meter_pulse_rate_volume_top.f
rtl/fmpr_pkg.sv
rtl/fmpr_div.sv
rtl/fmpr_dp.sv
rtl/fmpr_ctrl.sv
rtl/flow_meter_pulse_rate_volume_top.sv
rtl/fmpr_chk.sv
test/fmpr_report_checker.sv
test/flow_meter_pulse_rate_volume_top_tb.sv
